>>> rtl/sbrc_pkg.sv
// ----------------------------------------------------------------------------
// sbrc_pkg: shared types, codes and helper functions
// Holds the command codes, mode codes, chunk codes, the command and status
// structs between controller and datapath, and the word conversion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrc_pkg;

  // Cell kinds.
  localparam logic [1:0] CMD_INT  = 2'd0;
  localparam logic [1:0] CMD_NUM  = 2'd1;
  localparam logic [1:0] CMD_STR  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Modes. Any mode other than these behaves as compressed with an end chunk.
  localparam logic [1:0] MODE_UNCOMP    = 2'd0;
  localparam logic [1:0] MODE_END_CHUNK = 2'd1;
  localparam logic [1:0] MODE_ZSAV      = 2'd2;

  // Command byte codes.
  localparam logic signed [8:0] CODE_BIAS    = 9'sd100;
  localparam logic signed [8:0] COMPACT_MIN  = -9'sd99;
  localparam logic signed [8:0] COMPACT_MAX  = 9'sd151;
  localparam logic [7:0]        CODE_MISSING = 8'd255;
  localparam logic [7:0]        CODE_DATA    = 8'd253;
  localparam logic [7:0]        CODE_END     = 8'd252;

  localparam logic [63:0] NEG_DBL_MAX = 64'hFFEF_FFFF_FFFF_FFFF;

  localparam int unsigned SLOTS = 8;

  // Register indexes on the configuration port.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SWAP = 1'b1;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_CHUNK,
    SEL_PAY,
    SEL_END
  } out_sel_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [63:0]       value;
    logic signed [8:0] int_value;
    logic              int_missing;
    logic              last_cell;
  } cell_t;

  typedef struct packed {
    logic     accept;
    logic     load_out;
    out_sel_e out_sel;
    logic     out_last;
    logic     pop_pay;
  } dp_cmd_t;

  typedef struct packed {
    logic direct;
    logic flush;
    logic end_chunk;
    logic out_free;
    logic pend_any;
    logic pend_one;
    logic chunk_full;
  } dp_sts_t;

  function automatic logic [63:0] bswap64(input logic [63:0] w);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = w[8*(7-k) +: 8];
    end
    return r;
  endfunction

  function automatic logic is_bad_double(input logic [63:0] bits);
    return &bits[62:52];
  endfunction

  // Exact double of a 9-bit signed integer.
  function automatic logic [63:0] int_to_double(input logic signed [8:0] v);
    logic [8:0]  mag;
    logic [3:0]  p;
    logic [8:0]  norm;
    logic [10:0] expo;
    mag = v[8] ? 9'(-v) : 9'(v);
    p = 4'd0;
    for (int k = 1; k < 9; k++) begin
      if (mag[k]) p = 4'(k);
    end
    norm = mag << (4'd8 - p);
    expo = 11'd1023 + {7'd0, p};
    return (mag == 9'd0) ? 64'd0 : {v[8], expo, norm[7:0], 44'd0};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sbrc_cell_if.sv
// ----------------------------------------------------------------------------
// sbrc_cell_if: input cell channel
// Valid/ready channel carrying one cell of the record.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbrc_cell_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [63:0]       value;
  logic signed [8:0] int_value;
  logic              int_missing;
  logic              last_cell;

  modport source (
    output valid, command, value, int_value, int_missing, last_cell,
    input  ready
  );

  modport sink (
    input  valid, command, value, int_value, int_missing, last_cell,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sbrc_word_if.sv
// ----------------------------------------------------------------------------
// sbrc_word_if: output word channel
// Valid/ready channel carrying one 8-byte output word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbrc_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic        run_last;

  modport source (
    output valid, word, run_last,
    input  ready
  );

  modport sink (
    input  valid, word, run_last,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sbrc_datapath.sv
// ----------------------------------------------------------------------------
// sbrc_datapath: chunk assembly and output word register
// Builds the command chunk and the payload slots, computes per-cell status,
// and drives the output word register under controller command.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_datapath
  import sbrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cell_t       cell_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        swap_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_word_o,
  output logic             out_last_o
);

  logic [63:0]       chunk_q, chunk_d;
  logic [3:0]        slot_q, slot_d;
  logic [SLOTS-1:0]  present_q, present_d;
  logic [63:0]       words_q [SLOTS];
  logic [63:0]       direct_q;
  logic              out_valid_q;
  logic [63:0]       word_q;
  logic              run_last_q;

  logic              compressed;
  logic              takes_slot;
  logic [2:0]        slot;
  logic [3:0]        new_count;
  logic [7:0]        code;
  logic              has_pay;
  logic [63:0]       pay;
  logic [63:0]       direct_word;
  logic [2:0]        pay_idx;
  logic [63:0]       out_mux;
  logic [63:0]       int_dbl;

  assign compressed = (mode_i != MODE_UNCOMP);
  assign takes_slot = compressed && (cell_i.command != CMD_NONE);
  assign slot       = slot_q[2:0];
  assign new_count  = takes_slot ? slot_q + 4'd1 : slot_q;
  assign int_dbl    = int_to_double(cell_i.int_value);

  // Command byte and queued payload of the incoming cell.
  always_comb begin
    code    = CODE_DATA;
    has_pay = 1'b0;
    pay     = cell_i.value;
    unique case (cell_i.command)
      CMD_INT: begin
        if (cell_i.int_missing) begin
          code = CODE_MISSING;
        end else if (cell_i.int_value >= COMPACT_MIN && cell_i.int_value <= COMPACT_MAX) begin
          code = 8'(cell_i.int_value + CODE_BIAS);
        end else begin
          has_pay = 1'b1;
          pay     = swap_i ? bswap64(int_dbl) : int_dbl;
        end
      end
      CMD_NUM: begin
        if (is_bad_double(cell_i.value)) begin
          code = CODE_MISSING;
        end else begin
          has_pay = 1'b1;
          pay     = swap_i ? bswap64(cell_i.value) : cell_i.value;
        end
      end
      CMD_STR: begin
        has_pay = 1'b1;
      end
      default: begin
        code = 8'd0;
      end
    endcase
  end

  // Word for uncompressed pass-through.
  always_comb begin
    unique case (cell_i.command)
      CMD_INT: begin
        direct_word = cell_i.int_missing ? NEG_DBL_MAX : int_dbl;
        direct_word = swap_i ? bswap64(direct_word) : direct_word;
      end
      CMD_NUM: begin
        direct_word = is_bad_double(cell_i.value) ? NEG_DBL_MAX : cell_i.value;
        direct_word = swap_i ? bswap64(direct_word) : direct_word;
      end
      default: begin
        direct_word = cell_i.value;
      end
    endcase
  end

  // Lowest slot still holding a queued payload word.
  always_comb begin
    pay_idx = 3'd0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (present_q[k]) pay_idx = 3'(k);
    end
  end

  always_comb begin
    unique case (cmd_i.out_sel)
      SEL_DIRECT: out_mux = direct_q;
      SEL_CHUNK:  out_mux = swap_i ? bswap64(chunk_q) : chunk_q;
      SEL_PAY:    out_mux = words_q[pay_idx];
      SEL_END:    out_mux = swap_i ? bswap64({56'd0, CODE_END}) : {56'd0, CODE_END};
      default:    out_mux = direct_q;
    endcase
  end

  always_comb begin
    chunk_d   = chunk_q;
    slot_d    = slot_q;
    present_d = present_q;
    if (cmd_i.accept && takes_slot) begin
      chunk_d[8*slot +: 8] = chunk_q[8*slot +: 8] | code;
      present_d[slot]      = has_pay;
      slot_d               = new_count;
    end
    if (cmd_i.load_out && cmd_i.out_sel == SEL_CHUNK) begin
      chunk_d = '0;
      slot_d  = '0;
    end
    if (cmd_i.pop_pay) begin
      present_d[pay_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= '0;
      slot_q      <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chunk_q   <= chunk_d;
      slot_q    <= slot_d;
      present_q <= present_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && takes_slot && has_pay) begin
      words_q[slot] <= pay;
    end
    if (cmd_i.accept) begin
      direct_q <= direct_word;
    end
    if (cmd_i.load_out) begin
      word_q     <= out_mux;
      run_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.direct     = !compressed && (cell_i.command != CMD_NONE);
  assign sts_o.flush      = compressed &&
                            ((takes_slot && new_count == 4'(SLOTS)) ||
                             (cell_i.last_cell && new_count != 4'd0));
  assign sts_o.end_chunk  = compressed && cell_i.last_cell && (mode_i != MODE_ZSAV);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.pend_any   = |present_q;
  assign sts_o.pend_one   = (|present_q) && ((present_q & (present_q - 1'b1)) == '0);
  assign sts_o.chunk_full = (slot_q == 4'(SLOTS));

  assign out_valid_o = out_valid_q;
  assign out_word_o  = word_q;
  assign out_last_o  = run_last_q;

endmodule

`default_nettype wire

>>> rtl/sbrc_ctrl.sv
// ----------------------------------------------------------------------------
// sbrc_ctrl: sequencing controller
// Takes one cell, then walks the datapath through the words that the cell
// causes: pass-through word, or command word, queued payloads and end chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_ctrl
  import sbrc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIRECT = 3'd1;
  localparam logic [2:0] S_CMD    = 3'd2;
  localparam logic [2:0] S_PAY    = 3'd3;
  localparam logic [2:0] S_END    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       end_q, end_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    end_d          = end_q;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.out_sel  = SEL_DIRECT;
    cmd_o.out_last = 1'b0;
    cmd_o.pop_pay  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          end_d        = sts_i.end_chunk;
          if (sts_i.direct) begin
            state_d = S_DIRECT;
          end else if (sts_i.flush) begin
            state_d = S_CMD;
          end else if (sts_i.end_chunk) begin
            state_d = S_END;
          end
        end
      end
      S_DIRECT: begin
        cmd_o.out_sel  = SEL_DIRECT;
        cmd_o.out_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CMD: begin
        cmd_o.out_sel  = SEL_CHUNK;
        cmd_o.out_last = !sts_i.pend_any && !end_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.pend_any) begin
            state_d = S_PAY;
          end else if (end_q) begin
            state_d = S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PAY: begin
        cmd_o.out_sel  = SEL_PAY;
        cmd_o.out_last = sts_i.pend_one && !end_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.pop_pay  = 1'b1;
          if (sts_i.pend_one) begin
            state_d = end_q ? S_END : S_IDLE;
          end
        end
      end
      S_END: begin
        cmd_o.out_sel  = SEL_END;
        cmd_o.out_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sav_bytecode_record_compressor_top.sv
// Flow: a cell is taken in the idle state; the controller state register and
// then the output word register lie between it and its first word. The single
// output word register is fed one word per cycle while the output is free,
// and the next cell is taken only once every word of a cell is loaded.
// A new cell is taken while the last word of the previous one waits to go out.
// Reset: asynchronous, active low; mode 1, no byte swap, empty chunk.
// ----------------------------------------------------------------------------
// sav_bytecode_record_compressor_top: bytecode record compressor
// Packs cells into 8-slot command chunks with queued payload words, or passes
// them through uncompressed; configured over an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module sav_bytecode_record_compressor_top
  import sbrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sbrc_cell_if.sink        cell_i,
  sbrc_word_if.source      word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0] mode_q;
  logic       swap_q;
  logic       cfg_wr;
  cell_t      cell_in;
  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_END_CHUNK;
      swap_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE: mode_q <= pwdata[1:0];
        REG_SWAP: swap_q <= pwdata[0];
        default:  mode_q <= mode_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SWAP) ? {31'd0, swap_q} : {30'd0, mode_q};

  assign cell_in.command     = cell_i.command;
  assign cell_in.value       = cell_i.value;
  assign cell_in.int_value   = cell_i.int_value;
  assign cell_in.int_missing = cell_i.int_missing;
  assign cell_in.last_cell   = cell_i.last_cell;

  sbrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cell_i.valid),
    .in_ready_o (cell_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  sbrc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_i      (cell_in),
    .mode_i      (mode_q),
    .swap_i      (swap_q),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (word_o.valid),
    .out_ready_i (word_o.ready),
    .out_word_o  (word_o.word),
    .out_last_o  (word_o.run_last)
  );

  // A word is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> dp_sts.out_free)
    else $error("output word overwritten before it was taken");

  // A full chunk is always flushed before the next cell is taken.
  a_no_full_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.accept |-> !dp_sts.chunk_full)
    else $error("cell taken while the chunk is still full");

  // Payload words are only popped while some are queued.
  a_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.pop_pay |-> dp_sts.pend_any)
    else $error("payload popped with nothing queued");

  // After any chunk flush, full or partial, the chunk is no longer full.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.load_out && dp_cmd.out_sel == SEL_CHUNK) |=> !dp_sts.chunk_full)
    else $error("chunk not cleared after its command word");

endmodule

`default_nettype wire

>>> test/sav_bytecode_record_compressor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sav_bytecode_record_compressor_top_test: record compressor testbench
// Drives cells through directed corner cases and then random phases under
// every mode and byte order. It predicts each output word and its run_last
// flag, and compares every accepted word with the oldest prediction while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------

module sav_bytecode_record_compressor_top_test;
  import sbrc_pkg::*;

  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  localparam logic [7:0]  BLANK          = 8'h20;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned REPORT_CAP     = 50;
  localparam int unsigned PHASE_CELLS    = 44;
  localparam int unsigned PHASES         = 8;

  // Phase p uses bits [2p+1:2p] of the mode list and bit p of the swap list.
  localparam logic [15:0] PHASE_MODES = {MODE_UNCOMP, MODE_END_CHUNK, MODE_ZSAV,
                                         MODE_END_CHUNK, MODE_SPARE, MODE_UNCOMP,
                                         MODE_UNCOMP, MODE_ZSAV};
  localparam logic [7:0]  PHASE_SWAPS = 8'b1001_0011;

  typedef struct {
    logic [63:0] word;
    logic        run_last;
  } out_word_t;

  class word_stream_scoreboard;
    logic [1:0]  mode;
    logic        swap;
    logic [63:0] chunk;
    int unsigned slots;
    logic [63:0] pay [SLOTS];
    logic        present [SLOTS];
    out_word_t   expected_words [$];
    int unsigned mismatches;

    function new();
      mode = MODE_END_CHUNK;
      swap = 1'b0;
      chunk = '0;
      slots = 0;
      mismatches = 0;
      foreach (present[k]) present[k] = 1'b0;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
      if (idx == REG_MODE) begin
        mode = data[1:0];
      end else begin
        swap = data[0];
      end
    endfunction

    function logic [63:0] ordered(logic [63:0] w);
      if (!swap) return w;
      return {w[7:0], w[15:8], w[23:16], w[31:24], w[39:32], w[47:40], w[55:48], w[63:56]};
    endfunction

    function logic bad_double(logic [63:0] w);
      return w[62:52] == 11'h7FF;
    endfunction

    function logic [63:0] int_as_double(logic signed [8:0] v);
      logic [8:0]  mag;
      logic [63:0] frac;
      int          msb;
      if (v == 0) return '0;
      mag = v[8] ? 9'(-v) : 9'(v);
      msb = 0;
      for (int k = 0; k < 9; k++) begin
        if (mag[k]) msb = k;
      end
      frac = {55'd0, mag} << (52 - msb);
      return {v[8], 11'(1023 + msb), frac[51:0]};
    endfunction

    function void push_word(logic [63:0] w);
      out_word_t e;
      e.word = w;
      e.run_last = 1'b0;
      expected_words.insert(expected_words.size(), e);
    endfunction

    function void flush_chunk();
      push_word(ordered(chunk));
      for (int k = 0; k < SLOTS; k++) begin
        if (present[k]) push_word(pay[k]);
        present[k] = 1'b0;
      end
      chunk = '0;
      slots = 0;
    endfunction

    function void add_cell(cell_t c);
      int unsigned       count_before;
      logic signed [8:0] iv;
      logic [7:0]        code;
      logic              has;
      logic [63:0]       data;
      count_before = expected_words.size();
      iv = c.int_value;
      code = CODE_DATA;
      has = 1'b0;
      data = '0;
      if (mode == MODE_UNCOMP) begin
        case (c.command)
          CMD_INT: push_word(ordered(c.int_missing ? NEG_DBL_MAX : int_as_double(iv)));
          CMD_NUM: push_word(ordered(bad_double(c.value) ? NEG_DBL_MAX : c.value));
          CMD_STR: push_word(c.value);
          default: ;
        endcase
      end else begin
        if (c.command != CMD_NONE) begin
          case (c.command)
            CMD_INT: begin
              if (c.int_missing) begin
                code = CODE_MISSING;
              end else if (iv >= COMPACT_MIN && iv <= COMPACT_MAX) begin
                code = 8'(iv + CODE_BIAS);
              end else begin
                // Out of compact range: the exact double goes in the payload.
                has = 1'b1;
                data = ordered(int_as_double(iv));
              end
            end
            CMD_NUM: begin
              if (bad_double(c.value)) begin
                code = CODE_MISSING;
              end else begin
                has = 1'b1;
                data = ordered(c.value);
              end
            end
            default: begin
              has = 1'b1;
              data = c.value;
            end
          endcase
          chunk = chunk | (64'(code) << (8 * slots));
          present[slots] = has;
          if (has) pay[slots] = data;
          slots++;
          if (slots == SLOTS) flush_chunk();
        end
        if (c.last_cell) begin
          if (slots != 0) flush_chunk();
          if (mode != MODE_ZSAV) push_word(ordered(64'(CODE_END)));
        end
      end
      if (expected_words.size() > count_before) begin
        expected_words[expected_words.size() - 1].run_last = 1'b1;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_word(logic [63:0] w, logic run_last);
      out_word_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h arrived with nothing expected", w));
      end else begin
        e = expected_words.pop_front();
        if (e.word !== w) report($sformatf("word %h, expected %h", w, e.word));
        if (e.run_last !== run_last) begin
          report($sformatf("run_last %b on word %h, expected %b", run_last, w, e.run_last));
        end
      end
    endtask

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned cycle_count;

  sbrc_cell_if cell_if ();
  sbrc_word_if word_if ();

  word_stream_scoreboard board = new();

  sav_bytecode_record_compressor_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_if),
    .word_o  (word_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: ready walks a 16-bit pattern that is redrawn once it is used up,
  // sometimes solid, dense, plain random or sparse.
  initial begin
    logic [15:0] pattern;
    int unsigned pos;
    pattern = '1;
    pos = 0;
    word_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pos == 0) begin
        case ($urandom_range(0, 3))
          0:       pattern = '1;
          1:       pattern = 16'($urandom | $urandom);
          2:       pattern = 16'($urandom);
          default: pattern = 16'($urandom & $urandom);
        endcase
      end
      word_if.ready <= pattern[pos];
      pos = (pos + 1) % 16;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && word_if.valid && word_if.ready) begin
      board.check_word(word_if.word, word_if.run_last);
    end
  end

  task automatic apb_write(logic reg_idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.set_register(reg_idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_cell(cell_t c);
    cell_if.valid <= 1'b1;
    cell_if.command <= c.command;
    cell_if.value <= c.value;
    cell_if.int_value <= c.int_value;
    cell_if.int_missing <= c.int_missing;
    cell_if.last_cell <= c.last_cell;
    do @(posedge clk_i); while (cell_if.ready !== 1'b1);
    board.add_cell(c);
  endtask

  task automatic idle_cells(int unsigned cycles);
    cell_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // The settle time lets any word that arrives with nothing expected show up.
  task automatic drain_words();
    cell_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic cell_t make_cell(logic [1:0] command, logic [63:0] value,
                                      logic signed [8:0] int_value, logic missing,
                                      logic last);
    cell_t c;
    c.command = command;
    c.value = value;
    c.int_value = int_value;
    c.int_missing = missing;
    c.last_cell = last;
    return c;
  endfunction

  function automatic cell_t random_cell();
    cell_t       c;
    int unsigned pick;
    c.value = {$urandom, $urandom};
    c.int_value = 9'($urandom);
    c.int_missing = ($urandom_range(0, 9) == 0);
    c.last_cell = ($urandom_range(0, 24) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.command = CMD_INT;
      case ($urandom_range(0, 9))
        0:       c.int_missing = 1'b1;
        1, 2:    c.int_missing = 1'b0;
        default: begin
          c.int_missing = 1'b0;
          c.int_value = 9'(int'($urandom_range(0, 250)) - 99);
        end
      endcase
    end else if (pick < 70) begin
      c.command = CMD_NUM;
      if ($urandom_range(0, 5) == 0) begin
        c.value[62:52] = '1;
        if ($urandom_range(0, 2) == 0) c.value[51:0] = '0;
      end
    end else if (pick < 95) begin
      c.command = CMD_STR;
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 7; k >= int'($urandom_range(1, 7)); k--) c.value[8*k +: 8] = BLANK;
      end
    end else begin
      c.command = CMD_NONE;
    end
    return c;
  endfunction

  initial begin
    cell_t       directed [$];
    int unsigned burst_left;
    int unsigned gap;
    logic        quiet;

    rst_ni <= 1'b0;
    cell_if.valid <= 1'b0;
    cell_if.command <= CMD_INT;
    cell_if.value <= '0;
    cell_if.int_value <= '0;
    cell_if.int_missing <= 1'b0;
    cell_if.last_cell <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Corner cells under the reset settings: compact edges, out-of-range
    // integers, missing values, bad doubles, a full chunk, a partial flush,
    // a last cell with an empty chunk and a cell kind with no meaning.
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'sd0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, -9'sd99, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '1, 9'sd151, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, -9'sd100, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'sd152, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'h100, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'h0FF, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'sd5, 1'b1, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_NUM, 64'h3FF0_0000_0000_0000, '0, 1'b0, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_NUM, 64'h7FF8_0000_0000_0000, '0, 1'b0, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_NUM, 64'h7FF0_0000_0000_0000, '0, 1'b0, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_NUM, 64'hFFF0_0000_0000_0000, '0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_NUM, '0, '1, 1'b1, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_STR, 64'h4847_4645_4443_4241, '0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_NONE, '1, '1, 1'b1, 1'b0));
    directed.insert(directed.size(),
                    make_cell(CMD_STR, 64'h2020_2020_2020_6968, '0, 1'b0, 1'b1));
    directed.insert(directed.size(), make_cell(CMD_NONE, '0, '0, 1'b0, 1'b1));
    directed.insert(directed.size(),
                    make_cell(CMD_NUM, 64'h7FEF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_NUM, '1, '0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_STR, '1, '0, 1'b0, 1'b0));
    directed.insert(directed.size(), make_cell(CMD_INT, '0, 9'sd0, 1'b0, 1'b1));
    foreach (directed[k]) push_cell(directed[k]);
    drain_words();

    for (int p = 0; p < PHASES; p++) begin
      apb_write(REG_MODE, {30'd0, PHASE_MODES[2*p +: 2]});
      apb_write(REG_SWAP, {31'd0, PHASE_SWAPS[p]});
      quiet = (p == 4 || p == 6);
      burst_left = 0;
      for (int i = 0; i < PHASE_CELLS; i++) begin
        // Once per run the sender holds off until every word has come out.
        if (p == 1 && i == PHASE_CELLS / 2) begin
          drain_words();
          burst_left = $urandom_range(1, 12);
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = quiet ? 0 : $urandom_range(0, 6);
          if (gap > 0) idle_cells(gap);
        end
        burst_left--;
        push_cell(random_cell());
      end
      drain_words();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
